// ----- hdl/tehs_pkg.sv -----
`default_nettype none
package tehs_pkg;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int DELAY_W  = 15;
  localparam int HANDLE_W = 8;
  localparam int COUNT_W  = 6;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP    = 2'd3;

endpackage
`default_nettype wire

// ----- hdl/tehs_if.sv -----
`default_nettype none
// request channel: insert, tick, pop or nop
interface tehs_req_if import tehs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [DELAY_W-1:0]  delay;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, kind, delay, handle, input ready);
  modport sink   (input valid, kind, delay, handle, output ready);
endinterface

// result channel: one result per request
interface tehs_rsp_if import tehs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                event_valid;
  logic [HANDLE_W-1:0] event_handle;
  logic                late;
  logic                overflow;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, event_valid, event_handle, late, overflow, entry_count,
                  input ready);
  modport sink   (input valid, event_valid, event_handle, late, overflow, entry_count,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/timer_event_heap_scheduler.sv -----
`default_nettype none
// channel  | role   | payload
// req      | sink   | kind, delay, handle
// rsp      | source | event_valid, event_handle, late, overflow, entry_count
// cfg      | write  | cfg_wdata = run_enable, taken when cfg_we is high
//
// one request at a time; tick, nop, empty pop, full-heap insert go straight to S_OUT
// insert: UP and UPW per level climbed (up to log2 of depth), one heap memory read per level
// pop: PCHK, then if due DN and DNW per level descended; children from two read ports
// rst is synchronous; the heap is not cleared, only count, tick, ov, run_enable and state
// a new request is taken while a result waits in the output register
module timer_event_heap_scheduler import tehs_pkg::*; #(
  parameter int HEAP_DEPTH = 32,
  parameter int TICK_BITS  = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  tehs_req_if.sink   req,
  tehs_rsp_if.source rsp,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);

  localparam int MDEPTH = HEAP_DEPTH + 2;
  localparam int AW     = $clog2(MDEPTH);
  localparam int IW     = AW + 1;
  localparam int CW     = $clog2(HEAP_DEPTH + 1);
  localparam int DW     = TICK_BITS + HANDLE_W;
  localparam int SW     = TICK_BITS + DELAY_W;

  typedef enum logic [3:0] {
    S_IDLE, S_UP, S_UPW, S_PCHK, S_DN, S_DNW, S_FIN, S_OUT
  } state_t;

  state_t               state;
  logic                 run_enable;
  logic [TICK_BITS-1:0] cur_tick;
  logic [CW-1:0]        count;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        child;
  logic [IW-1:0]        n;
  logic [DW-1:0]        item;
  logic                 r_ev;
  logic [HANDLE_W-1:0]  r_handle;
  logic                 r_late;
  logic                 r_ovf;
  logic                 ov;
  logic                 o_ev;
  logic [HANDLE_W-1:0]  o_handle;
  logic                 o_late;
  logic                 o_ovf;
  logic [COUNT_W-1:0]   o_count;

  logic          we;
  logic [AW-1:0] wa;
  logic [DW-1:0] wd;
  logic [AW-1:0] ra;
  logic [AW-1:0] rb;
  logic [DW-1:0] qa;
  logic [DW-1:0] qb;

  tehs_mem #(.DEPTH(MDEPTH), .AW(AW), .DW(DW)) u_mem (
    .clk(clk), .we(we), .wa(wa), .wd(wd), .ra(ra), .rb(rb), .qa(qa), .qb(qb)
  );

  function automatic logic not_before(input logic [TICK_BITS-1:0] a,
                                      input logic [TICK_BITS-1:0] b);
    logic [TICK_BITS-1:0] d;
    d = a - b;
    return !d[TICK_BITS-1];
  endfunction

  // derived values
  logic                 accept;
  logic [SW-1:0]        dl_sum;
  logic [TICK_BITS-1:0] dl_new;
  logic [TICK_BITS-1:0] qa_dl;
  logic [TICK_BITS-1:0] qb_dl;
  logic [TICK_BITS-1:0] it_dl;
  logic [IW-1:0]        cnt_i;
  logic [IW-1:0]        up_par;
  logic                 pick_b;
  logic [DW-1:0]        c_data;
  logic [IW-1:0]        c_idx;
  logic [CW+COUNT_W-1:0] cnt_ext;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign dl_sum = {{DELAY_W{1'b0}}, cur_tick} + {{TICK_BITS{1'b0}}, req.delay};
  assign dl_new = dl_sum[TICK_BITS-1:0];
  assign qa_dl  = qa[DW-1:HANDLE_W];
  assign qb_dl  = qb[DW-1:HANDLE_W];
  assign it_dl  = item[DW-1:HANDLE_W];
  assign cnt_i  = IW'(count);
  assign up_par = idx >> 1;
  assign pick_b = (child < n) && not_before(qa_dl, qb_dl);
  assign c_data = pick_b ? qb : qa;
  assign c_idx  = pick_b ? child + IW'(1) : child;
  assign cnt_ext = {{COUNT_W{1'b0}}, count};

  // memory addressing per state
  always_comb begin
    ra = AW'(1);
    rb = cnt_i[AW-1:0];
    we = 1'b0;
    wa = idx[AW-1:0];
    wd = item;
    unique case (state)
      S_UP: begin
        ra = up_par[AW-1:0];
      end
      S_UPW: begin
        we = 1'b1;
        if (not_before(qa_dl, it_dl)) begin
          wd = qa;
        end
      end
      S_DN: begin
        ra = child[AW-1:0];
        rb = IW'(child + IW'(1)) > IW'(MDEPTH - 1) ? AW'(0)
             : AW'(child + IW'(1));
      end
      S_DNW: begin
        we = !not_before(c_data[DW-1:HANDLE_W], it_dl);
        wd = c_data;
      end
      S_FIN: begin
        we = (idx != n);
      end
      default: begin
      end
    endcase
  end

  // control sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      run_enable <= 1'b0;
      cur_tick   <= '0;
      count      <= '0;
      ov         <= 1'b0;
    end else begin
      if (cfg_we) begin
        run_enable <= cfg_wdata;
      end
      if (rsp.valid && rsp.ready && state != S_OUT) begin
        ov <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            r_ev     <= 1'b0;
            r_handle <= '0;
            r_late   <= 1'b0;
            r_ovf    <= 1'b0;
            state    <= S_OUT;
            if (req.kind == KIND_INSERT) begin
              if (cnt_i >= IW'(HEAP_DEPTH)) begin
                r_ovf <= 1'b1;
              end else begin
                count <= count + CW'(1);
                idx   <= cnt_i + IW'(1);
                item  <= {dl_new, req.handle};
                state <= S_UP;
              end
            end else if (req.kind == KIND_TICK) begin
              if (run_enable) begin
                cur_tick <= cur_tick + TICK_BITS'(1);
              end
            end else if (req.kind == KIND_POP) begin
              if (count != '0) begin
                n     <= cnt_i;
                state <= S_PCHK;
              end
            end
          end
        end
        S_UP: begin
          // root reached: place the new entry; else compare with the parent
          state <= (idx > IW'(1)) ? S_UPW : S_FIN;
          if (idx <= IW'(1)) begin
            n <= '0;
          end
        end
        S_UPW: begin
          if (not_before(qa_dl, it_dl)) begin
            idx   <= up_par;
            state <= S_UP;
          end else begin
            state <= S_OUT;
          end
        end
        S_PCHK: begin
          // due when current tick is not before the top deadline
          if (not_before(cur_tick, qa_dl)) begin
            r_ev     <= 1'b1;
            r_handle <= qa[HANDLE_W-1:0];
            r_late   <= !not_before(qa_dl, cur_tick);
            item     <= qb;
            idx      <= IW'(1);
            child    <= IW'(2);
            count    <= count - CW'(1);
            state    <= S_DN;
          end else begin
            state <= S_OUT;
          end
        end
        S_DN: begin
          state <= (child > n) ? S_FIN : S_DNW;
        end
        S_DNW: begin
          if (not_before(c_data[DW-1:HANDLE_W], it_dl)) begin
            state <= S_FIN;
          end else begin
            idx   <= c_idx;
            child <= c_idx << 1;
            state <= S_DN;
          end
        end
        S_FIN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!ov || rsp.ready) begin
            ov       <= 1'b1;
            o_ev     <= r_ev;
            o_handle <= r_handle;
            o_late   <= r_late;
            o_ovf    <= r_ovf;
            o_count  <= cnt_ext[COUNT_W-1:0];
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = ov;
  assign rsp.event_valid  = o_ev;
  assign rsp.event_handle = o_handle;
  assign rsp.late         = o_late;
  assign rsp.overflow     = o_ovf;
  assign rsp.entry_count  = o_count;

`ifndef SYNTHESIS
  // count stays within the heap
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt_i <= IW'(HEAP_DEPTH))
    else $error("heap count beyond depth");

  // no memory write while waiting for a request
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we)
    else $error("memory write while idle");

  // a late event is always a popped event
  a_late_valid: assert property (@(posedge clk) disable iff (rst)
    (ov && o_late) |-> o_ev)
    else $error("late flag without event");

  // overflow only on a full heap
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && r_ovf) |-> (cnt_i == IW'(HEAP_DEPTH)))
    else $error("overflow with room left");
`endif

endmodule
`default_nettype wire

// ----- hdl/tehs_mem.sv -----
`default_nettype none
// heap store: one write port, two registered read ports
module tehs_mem #(
  parameter int DEPTH = 34,
  parameter int AW    = 6,
  parameter int DW    = 24
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wa,
  input  wire logic [DW-1:0] wd,
  input  wire logic [AW-1:0] ra,
  input  wire logic [AW-1:0] rb,
  output logic      [DW-1:0] qa,
  output logic      [DW-1:0] qb
);

  logic [DW-1:0] mem [DEPTH];

  // write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    qa <= mem[ra];
    qb <= mem[rb];
  end

endmodule
`default_nettype wire

// ----- tb/timer_event_heap_scheduler_tb.sv -----
`default_nettype none
module timer_event_heap_scheduler_tb;
  import tehs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int TBITS = 16;

  typedef struct packed {
    logic                ev_valid;
    logic [HANDLE_W-1:0] ev_handle;
    logic                late;
    logic                overflow;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  tehs_req_if req ();
  tehs_rsp_if rsp ();

  timer_event_heap_scheduler #(.HEAP_DEPTH(DEPTH), .TICK_BITS(TBITS)) dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow timer queue
  logic             shadow_run;
  logic [TBITS-1:0] shadow_tick;
  logic [TBITS-1:0] shadow_dl [1:DEPTH];
  logic [7:0]       shadow_hd [1:DEPTH];
  int               shadow_count;

  outcome_t pending_outcomes[$];
  int errors = 0;
  int n_requests = 0;
  int n_pops_due = 0;
  int n_late = 0;
  int n_overflow = 0;

  function automatic bit at_or_after(logic [TBITS-1:0] a, logic [TBITS-1:0] b);
    logic [TBITS-1:0] d;
    d = a - b;
    return d[TBITS-1] == 1'b0;
  endfunction

  function automatic outcome_t schedule_step(logic [KIND_W-1:0] kind,
                                             logic [DELAY_W-1:0] delay,
                                             logic [HANDLE_W-1:0] handle);
    outcome_t o;
    int idx, child, n;
    logic [TBITS-1:0] dl, last;
    o = '0;
    if (kind == KIND_INSERT) begin
      if (shadow_count >= DEPTH) begin
        o.overflow = 1'b1;
      end else begin
        dl = shadow_tick + TBITS'(delay);
        shadow_count++;
        idx = shadow_count;
        while (idx > 1 && at_or_after(shadow_dl[idx/2], dl)) begin
          shadow_dl[idx] = shadow_dl[idx/2];
          shadow_hd[idx] = shadow_hd[idx/2];
          idx = idx / 2;
        end
        shadow_dl[idx] = dl;
        shadow_hd[idx] = handle;
      end
    end else if (kind == KIND_TICK) begin
      if (shadow_run) shadow_tick = shadow_tick + 1'b1;
    end else if (kind == KIND_POP) begin
      // due when deadline is not after the current tick
      if (shadow_count > 0 && at_or_after(shadow_tick, shadow_dl[1])) begin
        o.ev_valid = 1'b1;
        o.ev_handle = shadow_hd[1];
        o.late = shadow_dl[1] != shadow_tick;
        n = shadow_count;
        last = shadow_dl[n];
        idx = 1;
        child = 2;
        while (child <= n) begin
          if (child < n && at_or_after(shadow_dl[child], shadow_dl[child+1])) child++;
          if (at_or_after(shadow_dl[child], last)) break;
          shadow_dl[idx] = shadow_dl[child];
          shadow_hd[idx] = shadow_hd[child];
          idx = child;
          child = child * 2;
        end
        if (idx != n) begin
          shadow_dl[idx] = shadow_dl[n];
          shadow_hd[idx] = shadow_hd[n];
        end
        shadow_count = n - 1;
      end
    end
    o.count = COUNT_W'(shadow_count);
    return o;
  endfunction

  // send one request, random gap first
  task automatic send_request(logic [KIND_W-1:0] kind, logic [DELAY_W-1:0] delay,
                              logic [HANDLE_W-1:0] handle);
    outcome_t o;
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 9) < 3) gap = 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.kind   <= kind;
    req.delay  <= delay;
    req.handle <= handle;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    o = schedule_step(kind, delay, handle);
    pending_outcomes.push_back(o);
    n_requests++;
    if (o.ev_valid) n_pops_due++;
    if (o.late) n_late++;
    if (o.overflow) n_overflow++;
  endtask

  // result checker with random backpressure
  initial begin
    int stall;
    outcome_t got, exp_o;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      got = {rsp.event_valid, rsp.event_handle, rsp.late, rsp.overflow, rsp.entry_count};
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (got.ev_valid !== exp_o.ev_valid)
          $display("%0t: event_valid exp %0d got %0d", $time, exp_o.ev_valid, got.ev_valid);
        if (got.ev_handle !== exp_o.ev_handle)
          $display("%0t: event_handle exp %0d got %0d", $time, exp_o.ev_handle,
                   got.ev_handle);
        if (got.late !== exp_o.late)
          $display("%0t: late exp %0d got %0d", $time, exp_o.late, got.late);
        if (got.overflow !== exp_o.overflow)
          $display("%0t: overflow exp %0d got %0d", $time, exp_o.overflow, got.overflow);
        if (got.count !== exp_o.count)
          $display("%0t: entry_count exp %0d got %0d", $time, exp_o.count, got.count);
        if (got !== exp_o) errors++;
      end
    end
  end

  // wait until every result is back, then let the block settle
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_run(logic value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    shadow_run = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic ticks(int n);
    repeat (n) send_request(KIND_TICK, 15'($urandom), 8'($urandom));
  endtask

  // corners: empty pop, zero handle, max delay, equal deadlines, suspend, odd kind
  task automatic test_directed();
    send_request(KIND_POP, '0, '0);
    send_request(KIND_INSERT, '0, 8'hFF);
    send_request(KIND_INSERT, '0, 8'h00);
    send_request(KIND_INSERT, 15'h7FFF, 8'h55);
    send_request(KIND_INSERT, 15'd3, 8'hAA);
    send_request(KIND_NOP, 15'h7FFF, 8'hFF);
    send_request(KIND_POP, '0, '0);
    send_request(KIND_POP, '0, '0);
    send_request(KIND_POP, '0, '0);
    ticks(2);
    write_run(1'b1);
    ticks(5);
    send_request(KIND_POP, '0, '0);
    send_request(KIND_POP, '0, '0);
    write_run(1'b0);
  endtask

  // fill past capacity, then empty out late events
  task automatic test_overflow();
    write_run(1'b1);
    for (int i = 0; i < DEPTH + 3; i++)
      send_request(KIND_INSERT, 15'($urandom_range(0, 6)), 8'($urandom));
    ticks(10);
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(KIND_POP, 15'($urandom), 8'($urandom));
  endtask

  // random traffic with small delays so events come due
  task automatic test_random(int n, logic run);
    int r;
    write_run(run);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        send_request(KIND_INSERT, ($urandom_range(0, 9) == 0) ? 15'($urandom)
                     : 15'($urandom_range(0, 12)), 8'($urandom));
      else if (r < 65) send_request(KIND_TICK, 15'($urandom), 8'($urandom));
      else if (r < 98) send_request(KIND_POP, 15'($urandom), 8'($urandom));
      else send_request(KIND_NOP, 15'($urandom), 8'($urandom));
    end
  endtask

  // deadlines near half the tick range stay not due
  task automatic test_wrap();
    write_run(1'b1);
    send_request(KIND_INSERT, 15'h7FFF, 8'h11);
    send_request(KIND_INSERT, 15'h7FFE, 8'h22);
    repeat (60) send_request(KIND_TICK, '0, '0);
    repeat (3) send_request(KIND_POP, '0, '0);
  endtask

  initial begin
    req.valid = 1'b0;
    req.kind = KIND_TICK;
    req.delay = '0;
    req.handle = '0;
    shadow_run = 1'b0;
    shadow_tick = '0;
    shadow_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random(700, 1'b1);
    test_random(200, 1'b0);
    test_random(600, 1'b1);
    test_wrap();
    drain();
    $display("%0d requests, %0d due pops (%0d late), %0d overflows", n_requests,
             n_pops_due, n_late, n_overflow);
    $display("run enable toggled, heap filled past depth, far deadlines held back");
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #12ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
